@@ hdl/consistent_hash_ring_lookup_unit_assert.svh @@
// Assertion macros used by the ring sequencer (chrl_ring_seq).
// Needs no package; the including module supplies i_clk, i_rst_n and expressions.
`ifndef CONSISTENT_HASH_RING_LOOKUP_UNIT_ASSERT_SVH
`define CONSISTENT_HASH_RING_LOOKUP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CHRL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/chrl_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and interface structs of the hash ring lookup unit.
// No dependencies; imported by every module of the block.
package chrl_pkg;

    localparam int RING_ENTRIES = 64;
    localparam int IDX_W        = $clog2(RING_ENTRIES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int OWNER_BITS   = 8;
    localparam int POS_W        = 32;
    localparam int HASH_W       = 31;
    localparam int STEP_W       = $clog2(HASH_W);

    // stream payload widths (rounded up to whole bytes)
    localparam int S_TDATA_W = ((POS_W + OWNER_BITS + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OWNER_BITS + IDX_W + 7) / 8) * 8;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd3;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [HASH_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] rem;
    } t_mod_rsp;

    typedef struct packed {
        logic [OWNER_BITS-1:0] server;
        logic [IDX_W-1:0]      entry_index;
        logic [STATUS_W-1:0]   status;
    } t_result;

endpackage

@@ hdl/consistent_hash_ring_lookup_unit.sv @@
`timescale 1ns / 1ps
// Top level of the consistent hash ring lookup unit: stream ports, config
// register and output register. Depends on chrl_pkg and chrl_ring_seq.
//
// Usage:
//   One transaction on the slave stream carries one operation, selected by
//   s_axis_tuser: clear the ring, insert a position with its owner id, or
//   look up a key hash. Every transaction produces exactly one result
//   transaction on the master stream (owner id, entry index, status).
//   The modulus register is written through i_cfg_wr_en / i_cfg_wr_data
//   while the unit is idle; a value of zero skips the reduction.
// Sequencing:
//   One operation is in flight at a time; s_axis_tready is low while it runs.
//   Clear, no-op and empty lookup go straight to the result. Lookup: the
//   bit-serial 31-bit remainder (skipped for a zero modulus), up to
//   floor(log2(count)) + 1 binary search steps, then the owner read.
//   Insert: the binary search steps, the duplicate and full checks, then a
//   read and a write per entry moved to open the slot. The single-port ring
//   memory and the serial remainder set this step-by-step sequence.
// Reset: the ring is emptied (count cleared, memory left as is) and the
//   modulus returns to 2^31-1. No clearing pass is needed.
// Stall: a result waits in the output register; the next operation is
//   accepted meanwhile and holds in its final state until the slot frees.
module consistent_hash_ring_lookup_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [chrl_pkg::HASH_W-1:0]       i_cfg_wr_data,   // hash_space
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] ring_position, [39:32] owner_id, [71:40] key_hash
    input  logic [chrl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic [chrl_pkg::FUNC_W-1:0]       s_axis_tuser,    // [1:0] func
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] server, [13:8] entry_index, [15:14] zero
    output logic [chrl_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic [chrl_pkg::STATUS_W-1:0]     m_axis_tuser     // [1:0] status
);
    import chrl_pkg::*;

    localparam int OWN_LO = POS_W;
    localparam int KEY_LO = POS_W + OWNER_BITS;

    logic [HASH_W-1:0] r_hash_space;
    logic              r_out_valid;
    t_result           r_out;

    logic              seq_ready;
    logic              seq_res_valid;
    logic              res_ready;
    logic              start;
    t_result           seq_res;

    assign start     = s_axis_tvalid && seq_ready;
    assign res_ready = !r_out_valid || m_axis_tready;

    chrl_ring_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_func      (s_axis_tuser),
        .i_position  (s_axis_tdata[POS_W-1:0]),
        .i_owner     (s_axis_tdata[OWN_LO +: OWNER_BITS]),
        .i_key_hash  (s_axis_tdata[KEY_LO +: POS_W]),
        .i_hash_space(r_hash_space),
        .o_ready     (seq_ready),
        .o_res_valid (seq_res_valid),
        .i_res_ready (res_ready),
        .o_res       (seq_res)
    );

    // modulus register; reset selects the wrap-to-zero full range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_space <= '1;
        end else if (i_cfg_wr_en) begin
            r_hash_space <= i_cfg_wr_data;
        end
    end

    // output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_res_valid && res_ready) begin
            r_out <= seq_res;
        end
    end

    assign s_axis_tready = seq_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out.entry_index, r_out.server});
    assign m_axis_tuser  = r_out.status;

endmodule

@@ hdl/chrl_mod_unit.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on chrl_pkg for widths and the request/response structs.
module chrl_mod_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chrl_pkg::t_mod_req i_req,
    output chrl_pkg::t_mod_rsp o_rsp
);
    import chrl_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [HASH_W-1:0]   r_rem;
    logic [HASH_W-1:0]   r_dvd;
    logic [HASH_W-1:0]   r_div;
    logic [HASH_W:0]     n_trial;
    logic [HASH_W:0]     n_diff;

    // shift in next dividend bit, subtract when it fits
    assign n_trial = {r_rem, r_dvd[HASH_W-1]};
    assign n_diff  = n_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= STEP_W'(HASH_W - 1);
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_dvd <= {r_dvd[HASH_W-2:0], 1'b0};
            if (n_trial >= {1'b0, r_div}) begin
                r_rem <= n_diff[HASH_W-1:0];
            end else begin
                r_rem <= n_trial[HASH_W-1:0];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

@@ hdl/chrl_ring_seq.sv @@
`timescale 1ns / 1ps
// Ring sequencer: sorted position/owner memory, binary search, insert shift.
// Depends on chrl_pkg; drives its own chrl_mod_unit instance for key reduction.
module chrl_ring_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [chrl_pkg::FUNC_W-1:0]      i_func,
    input  logic [chrl_pkg::POS_W-1:0]       i_position,
    input  logic [chrl_pkg::OWNER_BITS-1:0]  i_owner,
    input  logic [chrl_pkg::POS_W-1:0]       i_key_hash,
    input  logic [chrl_pkg::HASH_W-1:0]      i_hash_space,
    output logic                             o_ready,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output chrl_pkg::t_result                o_res
);
    import chrl_pkg::*;

    `include "consistent_hash_ring_lookup_unit_assert.svh"

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_SRCH  = 4'd2;
    localparam logic [3:0] S_CMP   = 4'd3;
    localparam logic [3:0] S_LKOUT = 4'd4;
    localparam logic [3:0] S_DUP   = 4'd5;
    localparam logic [3:0] S_ROOM  = 4'd6;
    localparam logic [3:0] S_SHRD  = 4'd7;
    localparam logic [3:0] S_SHWR  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]              r_state;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_lo;
    logic [CNT_W-1:0]        r_hi;
    logic [CNT_W-1:0]        r_at;
    logic [CNT_W-1:0]        r_i;
    logic [FUNC_W-1:0]       r_func;
    logic [POS_W-1:0]        r_key;
    logic [OWNER_BITS-1:0]   r_owner;
    t_result                 r_res;

    logic [POS_W-1:0]        mem_pos [RING_ENTRIES];
    logic [OWNER_BITS-1:0]   mem_own [RING_ENTRIES];
    logic [POS_W-1:0]        r_rd_pos;
    logic [OWNER_BITS-1:0]   r_rd_own;

    logic [CNT_W-1:0]        mid;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [POS_W-1:0]        wr_pos;
    logic [OWNER_BITS-1:0]   wr_own;
    logic                    lk_wrap;
    t_mod_req                mod_req;
    t_mod_rsp                mod_rsp;

    chrl_mod_unit u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mod_req),
        .o_rsp  (mod_rsp)
    );

    assign mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign lk_wrap = (r_lo >= r_count);

    // memory addressing
    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_i[IDX_W-1:0];
        wr_pos  = r_rd_pos;
        wr_own  = r_rd_own;
        case (r_state)
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    rd_addr = mid[IDX_W-1:0];
                end else if (!lk_wrap) begin
                    rd_addr = r_lo[IDX_W-1:0];
                end
            end
            S_SHRD: begin
                if (r_i > r_at) begin
                    rd_addr = IDX_W'(r_i - 1'b1);
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_at[IDX_W-1:0];
                    wr_pos  = r_key;
                    wr_own  = r_owner;
                end
            end
            S_SHWR: begin
                wr_en = 1'b1;
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_pos[wr_addr] <= wr_pos;
            mem_own[wr_addr] <= wr_own;
        end
        r_rd_pos <= mem_pos[rd_addr];
        r_rd_own <= mem_own[rd_addr];
    end

    always_comb begin
        mod_req.start    = i_start && (r_state == S_IDLE) && (i_func == FUNC_LOOKUP)
                           && (r_count != '0) && (i_hash_space != '0);
        mod_req.dividend = i_key_hash[HASH_W-1:0];
        mod_req.divisor  = i_hash_space;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_func  <= i_func;
                        r_owner <= i_owner;
                        r_lo    <= '0;
                        r_hi    <= r_count;
                        case (i_func)
                            FUNC_CLEAR: begin
                                r_count <= '0;
                                r_res   <= '0;
                                r_state <= S_DONE;
                            end
                            FUNC_INSERT: begin
                                r_key   <= i_position;
                                r_res   <= '0;
                                r_state <= S_SRCH;
                            end
                            FUNC_LOOKUP: begin
                                r_key <= {1'b0, i_key_hash[HASH_W-1:0]};
                                if (r_count == '0) begin
                                    r_res   <= {{(OWNER_BITS + IDX_W){1'b0}}, ST_EMPTY};
                                    r_state <= S_DONE;
                                end else begin
                                    r_res   <= '0;
                                    r_state <= (i_hash_space == '0) ? S_SRCH : S_MOD;
                                end
                            end
                            default: begin
                                r_res   <= '0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    if (mod_rsp.done) begin
                        r_key   <= {1'b0, mod_rsp.rem};
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_at    <= mid;
                        r_state <= S_CMP;
                    end else if (r_func == FUNC_LOOKUP) begin
                        r_at    <= lk_wrap ? '0 : r_lo;
                        r_state <= S_LKOUT;
                    end else begin
                        r_at    <= r_lo;
                        r_state <= lk_wrap ? S_ROOM : S_DUP;
                    end
                end
                S_CMP: begin
                    // narrow the half-open window [lo, hi)
                    if ($signed(r_rd_pos) < $signed(r_key)) begin
                        r_lo <= r_at + 1'b1;
                    end else begin
                        r_hi <= r_at;
                    end
                    r_state <= S_SRCH;
                end
                S_LKOUT: begin
                    r_res.server      <= r_rd_own;
                    r_res.entry_index <= r_at[IDX_W-1:0];
                    r_state           <= S_DONE;
                end
                S_DUP: begin
                    if (r_rd_pos == r_key) begin
                        r_res.status <= ST_DUP;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_ROOM;
                    end
                end
                S_ROOM: begin
                    if (r_count >= CNT_W'(RING_ENTRIES)) begin
                        r_res.status <= ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_i     <= r_count;
                        r_state <= S_SHRD;
                    end
                end
                S_SHRD: begin
                    if (r_i > r_at) begin
                        r_state <= S_SHWR;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_SHWR: begin
                    r_i     <= r_i - 1'b1;
                    r_state <= S_SHRD;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    `CHRL_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(RING_ENTRIES), "count overflow")
    `CHRL_ASSERT_IMPL(a_probe, r_state == S_CMP, r_at < r_hi && r_hi <= r_count, "bad probe")
    `CHRL_ASSERT_IMPL(a_shift, r_state == S_SHWR, r_i > r_at && !r_i[IDX_W], "bad shift")
    `CHRL_ASSERT_IMPL(a_mod_range, mod_rsp.done, mod_rsp.rem < i_hash_space, "bad remainder")
    `CHRL_ASSERT_NEXT(a_mod_launch, mod_req.start, r_state == S_MOD, "bad modulo launch")

endmodule

@@ verif/tb_consistent_hash_ring_lookup_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for consistent_hash_ring_lookup_unit: drives clear, insert,
// lookup and no-op transactions; checks every result against an in-bench ring predictor.
// Depends on chrl_pkg and the unit RTL only.
module tb_consistent_hash_ring_lookup_unit;
    import chrl_pkg::*;

    // func value 3 is not decoded by the unit; it must come back as an all-zero result
    localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;
    localparam logic [HASH_W-1:0] WRAP_SPACE = 31'h7FFF_FFFF;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [HASH_W-1:0]       i_cfg_wr_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [31:0] ring_position, [39:32] owner_id, [71:40] key_hash
    logic [S_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [FUNC_W-1:0]       s_axis_tuser = '0;    // [1:0] func
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [7:0] server, [13:8] entry_index, [15:14] zero
    logic [M_TDATA_W-1:0]    m_axis_tdata;
    logic [STATUS_W-1:0]     m_axis_tuser;         // [1:0] status

    consistent_hash_ring_lookup_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Ring predictor state: sorted positions, their owners, and the modulus register
    logic signed [POS_W-1:0]      ring_pos   [0:RING_ENTRIES-1];
    logic        [OWNER_BITS-1:0] ring_owner [0:RING_ENTRIES-1];
    int                           ring_count = 0;
    logic        [HASH_W-1:0]     ring_space = WRAP_SPACE;

    t_result ring_results_due[$];
    t_result ring_want;

    logic [POS_W-1:0] dup_pool [0:15];
    bit  idle_on = 1'b0;
    int  rdy_hold = 0;

    int mismatch_count = 0;
    int n_insert = 0, n_dup = 0, n_full = 0, n_lookup = 0, n_empty = 0;
    int n_clear = 0, n_nop = 0, n_space_settings = 1;

    // First slot whose position is not below key (signed order); ring_count if none
    function automatic int ring_slot_for(input logic signed [POS_W-1:0] key);
        for (int i = 0; i < ring_count; i++)
            if (ring_pos[i] >= key)
                return i;
        return ring_count;
    endfunction

    // Apply one operation to the predicted ring and return the result it should give
    function automatic t_result ring_apply(input logic [FUNC_W-1:0] op,
                                           input logic signed [POS_W-1:0] pos,
                                           input logic [OWNER_BITS-1:0] owner,
                                           input logic [31:0] key);
        t_result             r;
        int                  at;
        logic [HASH_W-1:0]   h;
        r = '0;
        case (op)
            FUNC_CLEAR: begin
                ring_count = 0;
            end
            FUNC_INSERT: begin
                at = ring_slot_for(pos);
                // duplicate check wins over the full check
                if (at < ring_count && ring_pos[at] == pos) begin
                    r.status = ST_DUP;
                end else if (ring_count >= RING_ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = ring_count; i > at; i--) begin
                        ring_pos[i]   = ring_pos[i-1];
                        ring_owner[i] = ring_owner[i-1];
                    end
                    ring_pos[at]   = pos;
                    ring_owner[at] = owner;
                    ring_count++;
                end
            end
            FUNC_LOOKUP: begin
                if (ring_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    h = key[HASH_W-1:0];
                    if (ring_space == WRAP_SPACE) begin
                        if (h == WRAP_SPACE)
                            h = '0;
                    end else if (ring_space != '0) begin
                        h = h % ring_space;
                    end
                    at = ring_slot_for($signed({1'b0, h}));
                    // past the last position: wrap around to the first entry
                    if (at >= ring_count)
                        at = 0;
                    r.server      = ring_owner[at];
                    r.entry_index = IDX_W'(at);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void flag_mismatch(input string what, input longint unsigned want,
                                          input longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH at %0t ns, %s: expected %0h, got %0h", $time, what, want, got);
    endfunction

    // Result checker: each master-side transaction against the oldest due result
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (ring_results_due.size() == 0) begin
                flag_mismatch("result with none outstanding", 0, {m_axis_tuser, m_axis_tdata});
            end else begin
                ring_want = ring_results_due.pop_front();
                if (m_axis_tdata[OWNER_BITS-1:0] !== ring_want.server)
                    flag_mismatch("server", ring_want.server, m_axis_tdata[OWNER_BITS-1:0]);
                if (m_axis_tdata[OWNER_BITS +: IDX_W] !== ring_want.entry_index)
                    flag_mismatch("entry_index", ring_want.entry_index,
                                  m_axis_tdata[OWNER_BITS +: IDX_W]);
                if (m_axis_tuser !== ring_want.status)
                    flag_mismatch("status", ring_want.status, m_axis_tuser);
            end
        end
    end

    // Receiver back-pressure: random stall bursts while idling is on
    always @(posedge i_clk) begin
        if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else if (rdy_hold > 0) begin
            m_axis_tready <= 1'b0;
            rdy_hold      <= rdy_hold - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            rdy_hold      <= $urandom_range(0, 9);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Send one operation; valid stays high into the next call unless a gap is taken,
    // so it never sees two assignments in one time step.
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [OWNER_BITS-1:0] owner, input logic [31:0] key);
        t_result r;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {key, owner, pos};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        r = ring_apply(op, pos, owner, key);
        ring_results_due.insert(ring_results_due.size(), r);
        case (op)
            FUNC_CLEAR:  n_clear++;
            FUNC_INSERT: begin
                n_insert++;
                if (r.status == ST_DUP)  n_dup++;
                if (r.status == ST_FULL) n_full++;
            end
            FUNC_LOOKUP: begin
                n_lookup++;
                if (r.status == ST_EMPTY) n_empty++;
            end
            default:     n_nop++;
        endcase
    endtask

    // Hold the input side, let every result out, then write the modulus register
    task automatic write_hash_space(input logic [HASH_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (ring_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        ring_space = value;
        n_space_settings++;
    endtask

    // Edges of every field, every opcode, duplicate, empty lookup and wrap-around,
    // all under the reset modulus (wrap-to-zero mode)
    task automatic test_directed_edges();
        idle_on <= 1'b1;
        send_op(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 32'h0000_0000);   // empty ring
        send_op(FUNC_NOP,    32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send_op(FUNC_INSERT, 32'h7FFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send_op(FUNC_INSERT, 32'h8000_0000, 8'h00, 32'h0000_0000);
        send_op(FUNC_INSERT, 32'h0000_0000, 8'h11, 32'h0000_0000);
        send_op(FUNC_INSERT, 32'hFFFF_FFFF, 8'h22, 32'h0000_0000);
        send_op(FUNC_INSERT, 32'h0000_0000, 8'h33, 32'h0000_0000);   // duplicate, keep 8'h11
        send_op(FUNC_INSERT, 32'd1000,      8'h44, 32'h0000_0000);
        send_op(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 32'h7FFF_FFFF);   // masks to top, wraps to 0
        send_op(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 32'hFFFF_FFFF);
        send_op(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 32'h8000_0000);
        send_op(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 32'h7FFF_FFFE);
        send_op(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 32'd1000);
        send_op(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 32'd1001);
        send_op(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 32'h0000_0001);
        send_op(FUNC_CLEAR,  32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send_op(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 32'd5);           // empty after clear
        send_op(FUNC_INSERT, -32'sd5,       8'h01, 32'h0000_0000);
        send_op(FUNC_INSERT, 32'd100,       8'h02, 32'h0000_0000);
        send_op(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 32'd200);         // beyond all: entry 0
        send_op(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 32'd100);
        send_op(FUNC_NOP,    32'h0000_0000, 8'h00, 32'h0000_0000);
        send_op(FUNC_CLEAR,  32'h0000_0000, 8'h00, 32'h0000_0000);
    endtask

    // Fill the ring in descending order (worst-case shifting), then overflow it
    task automatic test_full_ring();
        logic [POS_W-1:0] p;
        for (int i = RING_ENTRIES - 1; i >= 0; i--) begin
            p = 32'h8000_0001 + i * 32'h0400_0000;
            send_op(FUNC_INSERT, p, OWNER_BITS'($urandom_range(0, 255)), $urandom);
        end
        send_op(FUNC_INSERT, 32'h7FFF_FFFF, 8'hA5, 32'h0000_0000);             // full
        send_op(FUNC_INSERT, 32'h8000_0001 + 5 * 32'h0400_0000, 8'h5A, 32'h0); // dup first
        send_op(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 32'h7FFF_FFFE);             // wraps to 0
        send_op(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 32'h8000_0000);
        repeat (6) send_op(FUNC_LOOKUP, $urandom, 8'h00, $urandom);
    endtask

    // One modulus setting: clear, then mostly inserts and lookups with random content,
    // positions biased into the reduced hash range and onto a small duplicate pool
    task automatic test_modulus_setting(input logic [HASH_W-1:0] space, input int n_ops,
                                        input bit idle);
        logic [31:0]         lim;
        logic [FUNC_W-1:0]   op;
        logic [POS_W-1:0]    pos;
        logic [31:0]         key;
        int                  r;
        idle_on <= idle;
        write_hash_space(space);
        lim = (space == '0 || space == WRAP_SPACE) ? 32'h7FFF_FFFF : {1'b0, space};
        foreach (dup_pool[i])
            dup_pool[i] = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, lim - 1);
        send_op(FUNC_CLEAR, $urandom, OWNER_BITS'($urandom), $urandom);
        repeat (n_ops) begin
            r = $urandom_range(0, 199);
            if (r < 2)       op = FUNC_CLEAR;
            else if (r < 6)  op = FUNC_NOP;
            else if (r < 96) op = FUNC_INSERT;
            else             op = FUNC_LOOKUP;

            r = $urandom_range(0, 9);
            if (r < 4)      pos = $urandom_range(0, lim - 1);
            else if (r < 6) pos = dup_pool[$urandom_range(0, 15)];
            else if (r < 9) pos = $urandom;
            else begin
                case ($urandom_range(0, 5))
                    0:       pos = 32'h8000_0000;
                    1:       pos = 32'h7FFF_FFFF;
                    2:       pos = 32'h0000_0000;
                    3:       pos = 32'hFFFF_FFFF;
                    4:       pos = lim - 1;
                    default: pos = lim;
                endcase
            end

            r = $urandom_range(0, 9);
            if (r < 4) begin
                key = $urandom;
            end else if (r < 7 && ring_count > 0) begin
                // land on, just below or just above a live position
                key = ring_pos[$urandom_range(0, ring_count - 1)] + $urandom_range(0, 2) - 1;
                key[31] = $urandom_range(0, 1);
            end else if (r < 9) begin
                key = {1'($urandom_range(0, 1)), 31'($urandom_range(0, lim - 1))};
            end else begin
                case ($urandom_range(0, 5))
                    0:       key = 32'h0000_0000;
                    1:       key = 32'h7FFF_FFFF;
                    2:       key = 32'hFFFF_FFFF;
                    3:       key = 32'h8000_0000;
                    4:       key = lim - 1;
                    default: key = lim;
                endcase
            end
            send_op(op, pos, OWNER_BITS'($urandom_range(0, 255)), key);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_full_ring();
        test_modulus_setting(WRAP_SPACE,                             170, 1'b1);
        test_modulus_setting(31'd0,                                  180, 1'b1);
        test_modulus_setting(31'd1,                                  120, 1'b1);
        test_modulus_setting(31'h7FFF_FFFE,                          150, 1'b1);
        test_modulus_setting(HASH_W'($urandom_range(2, 64)),         200, 1'b1);
        test_modulus_setting(HASH_W'($urandom_range(1000, 32'h7FFF_FFFE)), 200, 1'b1);
        test_modulus_setting(HASH_W'($urandom_range(1, 65536)),      200, 1'b1);
        // closing stretch runs at full rate on both sides
        test_modulus_setting(WRAP_SPACE,                             230, 1'b0);

        // drain, then give the unit time to show any stray result
        s_axis_tvalid <= 1'b0;
        while (ring_results_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (ring_results_due.size() != 0)
            flag_mismatch("results still outstanding", 0, ring_results_due.size());

        $display("Covered %0d inserts (%0d duplicate, %0d on a full ring),",
                 n_insert, n_dup, n_full);
        $display("%0d lookups (%0d empty), %0d clears and %0d unused-opcode transactions",
                 n_lookup, n_empty, n_clear, n_nop);
        $display("over %0d modulus settings; %0d mismatches.",
                 n_space_settings, mismatch_count);
        if (mismatch_count == 0)
            $display("consistent_hash_ring_lookup_unit test passed");
        else
            $display("consistent_hash_ring_lookup_unit test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (full-ring inserts with maximum stalls)
    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", ring_results_due.size());
        $display("consistent_hash_ring_lookup_unit test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/chrl_pkg.sv
hdl/chrl_mod_unit.sv
hdl/chrl_ring_seq.sv
hdl/consistent_hash_ring_lookup_unit.sv
verif/tb_consistent_hash_ring_lookup_unit.sv
